/* src/sidec_pkg.sv */
// ----------------------------------------------------------------------------
// sidec_pkg
// Shared types, constants and BCD helpers for the signed integer to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package sidec_pkg;

	localparam int VALUE_W       = 32;
	localparam int NUM_DIGITS    = 10;
	localparam int BCD_W         = 4 * NUM_DIGITS;
	localparam int BITS_PER_STEP = 4;
	localparam int NUM_STEPS     = VALUE_W / BITS_PER_STEP;
	localparam int STEP_CNT_W    = $clog2(NUM_STEPS);

	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_PREP,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic prep;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic conv_last;
		logic negative;
		logic idx_zero;
		logic out_free;
	} status_t;

	// shift-add-3 correction on every BCD digit
	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
		logic [BCD_W-1:0] res;
		res = bcd;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (bcd[4*d +: 4] > 4'd4) begin
				res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
			end
		end
		return res;
	endfunction

	// index of the most significant nonzero digit, 0 when all are zero
	function automatic logic [3:0] msd_index(input logic [BCD_W-1:0] bcd);
		logic [3:0] idx;
		idx = 4'd0;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (bcd[4*d +: 4] != 4'd0) begin
				idx = 4'(d);
			end
		end
		return idx;
	endfunction

endpackage

/* src/sidec_ctrl.sv */
// ----------------------------------------------------------------------------
// sidec_ctrl
// Sequencer: accepts a word, runs the BCD conversion steps, then emits the
// sign of a negative word and the digits one character per free output slot.
// ----------------------------------------------------------------------------
module sidec_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sidec_pkg::status_t  status,
	output sidec_pkg::cmd_t     cmd
);

	sidec_pkg::state_t state_q;
	sidec_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sidec_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sidec_pkg::ST_IDLE: begin
				if (in_valid) state_d = sidec_pkg::ST_CONV;
			end
			sidec_pkg::ST_CONV: begin
				if (status.conv_last) state_d = sidec_pkg::ST_PREP;
			end
			sidec_pkg::ST_PREP: begin
				state_d = status.negative ? sidec_pkg::ST_SIGN : sidec_pkg::ST_DIGITS;
			end
			sidec_pkg::ST_SIGN: begin
				if (status.out_free) state_d = sidec_pkg::ST_DIGITS;
			end
			sidec_pkg::ST_DIGITS: begin
				if (status.out_free && status.idx_zero) state_d = sidec_pkg::ST_IDLE;
			end
			default: state_d = sidec_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sidec_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sidec_pkg::ST_CONV:   cmd.step       = 1'b1;
			sidec_pkg::ST_PREP:   cmd.prep       = 1'b1;
			sidec_pkg::ST_SIGN:   cmd.emit_sign  = status.out_free;
			sidec_pkg::ST_DIGITS: cmd.emit_digit = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

/* src/sidec_dp.sv */
// ----------------------------------------------------------------------------
// sidec_dp
// Datapath: magnitude, 4-bit-per-cycle double dabble into ten BCD digits,
// digit index and the output character register.
// ----------------------------------------------------------------------------
module sidec_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic signed [sidec_pkg::VALUE_W-1:0]   value,
	input  sidec_pkg::cmd_t                         cmd,
	output sidec_pkg::status_t                      status,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [7:0]                              text_char,
	output logic                                    last
);

	logic [sidec_pkg::VALUE_W-1:0]    mag_q;
	logic [sidec_pkg::BCD_W-1:0]      bcd_q;
	logic                             neg_q;
	logic [sidec_pkg::STEP_CNT_W-1:0] step_q;
	logic [3:0]                       idx_q;
	logic                             out_valid_q;
	logic [7:0]                       char_q;
	logic                             last_q;

	logic [sidec_pkg::VALUE_W-1:0]    value_u;
	logic [sidec_pkg::VALUE_W-1:0]    mag_d;
	logic [sidec_pkg::BCD_W-1:0]      bcd_d;
	logic [3:0]                       digit;

	assign value_u = value;

	always_comb begin
		mag_d = mag_q;
		bcd_d = bcd_q;
		for (int b = 0; b < sidec_pkg::BITS_PER_STEP; b++) begin
			bcd_d = sidec_pkg::bcd_adjust(bcd_d);
			bcd_d = {bcd_d[sidec_pkg::BCD_W-2:0], mag_d[sidec_pkg::VALUE_W-1]};
			mag_d = {mag_d[sidec_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	assign digit = bcd_q[{idx_q, 2'b00} +: 4];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= value_u[sidec_pkg::VALUE_W-1] ? (~value_u + 32'd1) : value_u;
			neg_q <= value_u[sidec_pkg::VALUE_W-1];
			bcd_q <= '0;
		end else if (cmd.step) begin
			mag_q <= mag_d;
			bcd_q <= bcd_d;
		end
		if (cmd.prep) begin
			idx_q <= sidec_pkg::msd_index(bcd_q);
		end else if (cmd.emit_digit) begin
			idx_q <= idx_q - 4'd1;
		end
		if (cmd.emit_sign) begin
			char_q <= sidec_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= sidec_pkg::CHAR_ZERO + {4'd0, digit};
			last_q <= (idx_q == 4'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.emit_sign || cmd.emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.conv_last = (step_q == sidec_pkg::STEP_CNT_W'(sidec_pkg::NUM_STEPS - 1));
	assign status.negative  = neg_q;
	assign status.idx_zero  = (idx_q == 4'd0);
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last      = last_q;

endmodule

/* src/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit word to its decimal ASCII text, one character per
// output word, most significant first, last flag on the final character.
// Each word passes through the accept state, 8 conversion steps of 4 bits
// each, a prep state and one character per free output slot, N = 1..11
// characters per word; a new word is accepted only after the last character
// of the previous word has been emitted.
// Reset: arst_n clears the sequencer, step counter and output valid; no other state.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [sidec_pkg::VALUE_W-1:0] value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [7:0]                            text_char,
	output logic                                  last
);

	sidec_pkg::cmd_t    cmd;
	sidec_pkg::status_t status;

	sidec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sidec_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.text_char (text_char),
		.last      (last)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (text_char == sidec_pkg::CHAR_MINUS) |-> !last)
		else $error("minus sign flagged as last");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (text_char == sidec_pkg::CHAR_MINUS) ||
			((text_char >= sidec_pkg::CHAR_ZERO) && (text_char <= 8'd57)))
		else $error("illegal output character");
`endif

endmodule

/* tb/signed_int_to_decimal_ascii_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Drives signed 32-bit words into the converter and checks every output
// character and last flag against decimal text predicted in the bench.
// Directed edge values come first, then random words under changing
// sender and receiver idle rates.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 25;
	localparam int DECIMAL_RADIX = 10;

	typedef struct packed {
		logic [7:0] character;
		logic       last_flag;
	} text_word_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	logic signed [sidec_pkg::VALUE_W-1:0] value;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic [7:0]                           text_char;
	logic                                 last;

	text_word_t text_expected[$];
	text_word_t expected_word;
	int         fail_count     = 0;
	int         cycle_count    = 0;
	int         send_gap_pct   = 0;
	int         recv_stall_pct = 0;

	signed_int_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.text_char (text_char),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// decimal text of one word, sign first when negative, digits most significant first
	task automatic push_decimal_text(input logic [sidec_pkg::VALUE_W-1:0] v);
		logic [sidec_pkg::VALUE_W-1:0] mag;
		logic [3:0]                    digs[sidec_pkg::NUM_DIGITS];
		int                            n;
		mag = v[sidec_pkg::VALUE_W-1] ? -v : v;
		n   = 0;
		do begin
			digs[n] = 4'(mag % DECIMAL_RADIX);
			mag     = mag / DECIMAL_RADIX;
			n++;
		end while (mag != 0);
		if (v[sidec_pkg::VALUE_W-1])
			text_expected.push_back('{character: sidec_pkg::CHAR_MINUS, last_flag: 1'b0});
		for (int k = n - 1; k >= 0; k--)
			text_expected.push_back('{character: sidec_pkg::CHAR_ZERO + 8'(digs[k]),
				last_flag: (k == 0)});
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (text_expected.size() == 0) begin
				$error("unexpected output word: text_char %0d, last %0d", text_char, last);
				fail_count++;
			end else begin
				expected_word = text_expected.pop_front();
				if (text_char !== expected_word.character) begin
					$error("text_char: expected %0d, got %0d",
						expected_word.character, text_char);
					fail_count++;
				end
				if (last !== expected_word.last_flag) begin
					$error("last: expected %0d, got %0d", expected_word.last_flag, last);
					fail_count++;
				end
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input logic [sidec_pkg::VALUE_W-1:0] v);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		push_decimal_text(v);
		@(negedge clk);
	endtask

	task automatic wait_text_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (text_expected.size() != 0);
	endtask

	// values of a random digit count, plus raw words, small values and near-extremes
	function automatic logic [sidec_pkg::VALUE_W-1:0] random_value();
		longint lo, hi, mag;
		int     ndig;
		logic   neg;
		neg = 1'($urandom_range(1));
		case ($urandom_range(5))
			0, 1: return $urandom;
			2: begin
				mag = $urandom_range(99);
			end
			3: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
				: 32'h7fff_ffff - $urandom_range(3);
			default: begin
				ndig = $urandom_range(sidec_pkg::NUM_DIGITS, 1);
				lo   = (ndig == 1) ? 64'sd0 : 64'sd10 ** (ndig - 1);
				hi   = 64'sd10 ** ndig - 64'sd1;
				if (hi > 64'sd2147483647) hi = neg ? 64'sd2147483648 : 64'sd2147483647;
				mag  = lo + longint'($urandom) % (hi - lo + 1);
			end
		endcase
		return neg ? sidec_pkg::VALUE_W'(-mag) : sidec_pkg::VALUE_W'(mag);
	endfunction

	task automatic test_zero();
		send_word(32'sd0);
	endtask

	task automatic test_extremes();
		send_word(32'sh7fff_ffff);
		send_word(32'sh8000_0000);
		send_word(32'sh8000_0001);
		send_word(-32'sd1);
		send_word(32'sh5555_5555);
		send_word(32'shAAAA_AAAA);
	endtask

	task automatic test_digit_counts();
		send_word(32'sd1);
		send_word(32'sd9);
		send_word(32'sd10);
		send_word(32'sd99);
		send_word(32'sd100);
		send_word(32'sd999999999);
		send_word(32'sd1000000000);
		send_word(-32'sd9);
		send_word(-32'sd10);
		send_word(-32'sd999999999);
		send_word(-32'sd1000000000);
		send_word(32'sd123456789);
		send_word(-32'sd123456789);
	endtask

	// sender holds off until the output side has fully drained
	task automatic test_drain_pause();
		send_word(random_value());
		send_word(random_value());
		wait_text_drained();
		send_word(32'sh8000_0000);
		wait_text_drained();
		send_word(random_value());
	endtask

	task automatic test_random(input int count);
		repeat (count) send_word(random_value());
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		value    = '0;
		send_gap_pct   = 32;
		recv_stall_pct = 54;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_zero();
		test_extremes();
		test_digit_counts();
		test_drain_pause();
		test_random(80);

		send_gap_pct   = 54;
		recv_stall_pct = 32;
		test_random(80);

		send_gap_pct   = 0;
		recv_stall_pct = 0;
		test_random(80);

		in_valid <= 1'b0;
		while (text_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (text_expected.size() != 0) begin
			$error("%0d expected output words never arrived", text_expected.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
